/* rtl/bssl_pkg.sv */
// Package for the bounded sorted score list: sizes, command and status codes,
// and the request, result, command and status structs.
// No dependencies.
package bssl_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int NRES        = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RANK_W      = 4;
  localparam int TAG_W       = 64;
  localparam int SCORE_W     = 32;
  localparam int STAMP_W     = 32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic [TAG_W-1:0]          entry_tag;
    logic signed [SCORE_W-1:0] new_score;
    logic [STAMP_W-1:0]        stamp;
  } in_req_t;

  typedef struct packed {
    logic                      status;
    logic                      valid_res;
    logic [RANK_W-1:0]         rank;
    logic [TAG_W-1:0]          tag_out;
    logic signed [SCORE_W-1:0] score_out;
    logic [STAMP_W-1:0]        stamp_out;
    logic                      last;
  } out_res_t;

  typedef struct packed {
    logic do_insert;
    logic rd_start;
    logic rd_next;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic multi;
    logic rd_last;
  } dp_status_t;

endpackage

/* rtl/bssl_ctrl.sv */
// Controller for the bounded sorted score list: accepts requests and steps
// the datapath through a read. Depends on bssl_pkg.
module bssl_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_cmd,
  output logic                    in_stall,
  input  bssl_pkg::dp_status_t    st,
  output bssl_pkg::dp_cmd_t       cmd
);

  typedef enum logic {IDLE, READ} state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = (state_r == IDLE) && in_valid && st.out_free;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state_r)
      IDLE: begin
        in_stall = !st.out_free;
        if (accept) begin
          if (in_cmd == bssl_pkg::CMD_READ) begin
            cmd.rd_start = 1'b1;
            if (st.multi) state_nxt = READ;
          end else begin
            cmd.do_insert = 1'b1;
          end
        end
      end
      READ: begin
        if (st.out_free) begin
          cmd.rd_next = 1'b1;
          if (st.rd_last) state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/bssl_dp.sv */
// Datapath for the bounded sorted score list: compare-and-shift slot chain,
// fill count, read index and result register. Depends on bssl_pkg.
module bssl_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bssl_pkg::in_req_t       req,
  input  bssl_pkg::dp_cmd_t       cmd,
  output bssl_pkg::dp_status_t    st,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bssl_pkg::out_res_t      out_res
);

  localparam int D = bssl_pkg::DEPTH;
  localparam int IW = bssl_pkg::IDX_W;
  localparam int CW = bssl_pkg::CNT_W;

  logic [bssl_pkg::TAG_W-1:0]          tags_r   [D];
  logic signed [bssl_pkg::SCORE_W-1:0] scores_r [D];
  logic [bssl_pkg::STAMP_W-1:0]        stamps_r [D];

  logic [CW-1:0]      fill_r, fill_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  bssl_pkg::out_res_t out_r, out_nxt;

  logic [D-1:0]  gt, gt_prev, hit;
  logic [IW-1:0] pos, rd_sel;
  logic          full;
  logic [CW-1:0] n_res;
  logic          load;

  assign full  = (fill_r == CW'(D));
  assign n_res = (fill_r > CW'(bssl_pkg::NRES)) ? CW'(bssl_pkg::NRES) : fill_r;

  always_comb begin
    pos = '0;
    for (int i = 0; i < D; i++) begin
      gt[i] = (CW'(i) < fill_r) && (scores_r[i] > req.new_score);
    end
    gt_prev = {gt[D-2:0], 1'b1};
    for (int i = 0; i < D; i++) begin
      hit[i] = !gt[i] && gt_prev[i];
      if (hit[i]) pos = pos | IW'(i);
    end
  end

  assign rd_sel = cmd.rd_start ? '0 : rd_idx_r;

  assign st.out_free = !out_valid_r || !out_stall;
  assign st.multi    = (n_res > CW'(1));
  assign st.rd_last  = ((CW'(rd_idx_r) + CW'(1)) == n_res);

  assign load = cmd.do_insert || cmd.rd_start || cmd.rd_next;

  always_comb begin
    out_nxt       = out_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) out_valid_nxt = 1'b1;
    if (cmd.do_insert) begin
      out_nxt = '0;
      out_nxt.last = 1'b1;
      if (full) begin
        out_nxt.status = bssl_pkg::ST_FULL;
      end else begin
        out_nxt.status    = bssl_pkg::ST_OK;
        out_nxt.valid_res = 1'b1;
        out_nxt.rank      = bssl_pkg::RANK_W'(pos);
        out_nxt.tag_out   = req.entry_tag;
        out_nxt.score_out = req.new_score;
        out_nxt.stamp_out = req.stamp;
        fill_nxt          = fill_r + CW'(1);
      end
    end else if (cmd.rd_start || cmd.rd_next) begin
      out_nxt.status    = bssl_pkg::ST_OK;
      out_nxt.valid_res = (fill_r != '0);
      out_nxt.rank      = bssl_pkg::RANK_W'(rd_sel);
      out_nxt.tag_out   = tags_r[rd_sel];
      out_nxt.score_out = scores_r[rd_sel];
      out_nxt.stamp_out = stamps_r[rd_sel];
      if (cmd.rd_start) begin
        out_nxt.last = !st.multi;
        rd_idx_nxt   = IW'(1);
      end else begin
        out_nxt.last = st.rd_last;
        rd_idx_nxt   = rd_idx_r + IW'(1);
      end
      if (fill_r == '0) begin
        out_nxt.tag_out   = '0;
        out_nxt.score_out = '0;
        out_nxt.stamp_out = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_insert && !full) begin
      for (int i = 0; i < D; i++) begin
        if (hit[i]) begin
          tags_r[i]   <= req.entry_tag;
          scores_r[i] <= req.new_score;
          stamps_r[i] <= req.stamp;
        end
      end
      for (int i = 1; i < D; i++) begin
        if (!gt[i] && !hit[i]) begin
          tags_r[i]   <= tags_r[i-1];
          scores_r[i] <= scores_r[i-1];
          stamps_r[i] <= stamps_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r    <= out_nxt;
    rd_idx_r <= rd_idx_nxt;
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

/* rtl/bounded_sorted_score_list.sv */
// Bounded sorted score list, top level: controller plus datapath.
// Depends on bssl_pkg, bssl_ctrl and bssl_dp.
//
// Requests enter on in_valid/in_stall with in_req; results leave on
// out_valid/out_stall with out_res. A request is taken on a clock edge with
// valid high and stall low.
// On an insert the slot chain compares all stored scores with the new one and
// shifts the entries scoring no higher down a place at once; its single
// result shows in the output register on the next cycle.
// A read emits min(entries, 16) results, one per cycle while the receiver does
// not stall, from the output register; the fill count sets that figure. An empty
// board gives one invalid result. No request is taken while a read drains.
// When the receiver stalls, the output register holds its result and no
// further request is taken until it frees.
// Reset (rst_n low, synchronous) empties the board and drops any pending
// result; slot contents are not cleared.
module bounded_sorted_score_list (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bssl_pkg::in_req_t     in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bssl_pkg::out_res_t    out_res
);

  bssl_pkg::dp_cmd_t    cmd;
  bssl_pkg::dp_status_t st;

  bssl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_req.cmd),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bssl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

`ifndef SYNTH
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_insert, cmd.rd_start, cmd.rd_next}))
    else $error("more than one datapath command at once");

  a_next_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_next |-> st.out_free)
    else $error("read step while output register blocked");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  a_no_req_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_start && st.multi) |=> in_stall)
    else $error("request accepted while a read drains");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for bounded_sorted_score_list: directed and random insert
// and read requests with its own board model, a driver and a monitor with random stalls.
// Depends on bssl_pkg and the bounded_sorted_score_list RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bssl_pkg::*;

  localparam int RANDOM_REQS = 490;
  localparam int TAIL_REQS   = 80;
  localparam int LONG_AT     = 150;
  localparam int LONG_HOLD   = 80;
  localparam int PAUSE_AT    = 320;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [TAG_W-1:0]          tag;
    logic signed [SCORE_W-1:0] score;
    logic [STAMP_W-1:0]        stamp;
  } board_slot_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;

  in_req_t     requests_to_send[$];
  out_res_t    rank_reports_due[$];
  board_slot_t board[DEPTH];
  int          board_fill;
  int          total_reqs;
  int          sent_count;
  int          send_gap;
  int          recv_hold;
  bit          long_hold_done;
  int          mismatches;
  int          cycle_count;

  bounded_sorted_score_list DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic in_req_t make_insert(logic [TAG_W-1:0] tag, logic [SCORE_W-1:0] score,
                                          logic [STAMP_W-1:0] stamp);
    in_req_t rq;
    rq.cmd       = CMD_INSERT;
    rq.entry_tag = tag;
    rq.new_score = score;
    rq.stamp     = stamp;
    return rq;
  endfunction

  function automatic in_req_t make_read();
    in_req_t rq;
    rq     = '0;
    rq.cmd = CMD_READ;
    return rq;
  endfunction

  function automatic bit in_tail();
    return (total_reqs - sent_count) < TAIL_REQS;
  endfunction

  // Update the board and queue the reports one request causes.
  function automatic void apply_to_board(in_req_t rq);
    out_res_t r;
    int pos;
    int n;
    int i;
    if (rq.cmd == CMD_INSERT) begin
      r      = '0;
      r.last = 1'b1;
      if (board_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < board_fill &&
               $signed(rq.new_score) < $signed(board[IDX_W'(pos)].score))
          pos++;
        for (i = board_fill; i > pos; i--)
          board[IDX_W'(i)] = board[IDX_W'(i-1)];
        board[IDX_W'(pos)].tag   = rq.entry_tag;
        board[IDX_W'(pos)].score = rq.new_score;
        board[IDX_W'(pos)].stamp = rq.stamp;
        board_fill++;
        r.status    = ST_OK;
        r.valid_res = 1'b1;
        r.rank      = pos[RANK_W-1:0];
        r.tag_out   = rq.entry_tag;
        r.score_out = rq.new_score;
        r.stamp_out = rq.stamp;
      end
      rank_reports_due.push_back(r);
    end else begin
      n = (board_fill < NRES) ? board_fill : NRES;
      if (n == 0) begin
        r      = '0;
        r.last = 1'b1;
        rank_reports_due.push_back(r);
      end else begin
        for (i = 0; i < n; i++) begin
          r           = '0;
          r.status    = ST_OK;
          r.valid_res = 1'b1;
          r.rank      = i[RANK_W-1:0];
          r.tag_out   = board[IDX_W'(i)].tag;
          r.score_out = board[IDX_W'(i)].score;
          r.stamp_out = board[IDX_W'(i)].stamp;
          r.last      = (i == n - 1);
          rank_reports_due.push_back(r);
        end
      end
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_report(out_res_t got);
    out_res_t want;
    if (rank_reports_due.size() == 0) begin
      $error("unexpected result: %p", got);
      mismatches++;
    end else begin
      want = rank_reports_due.pop_front();
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("valid_res", 64'(want.valid_res), 64'(got.valid_res));
      check_field("rank", 64'(want.rank), 64'(got.rank));
      check_field("tag_out", want.tag_out, got.tag_out);
      check_field("score_out", 64'(want.score_out), 64'(got.score_out));
      check_field("stamp_out", 64'(want.stamp_out), 64'(got.stamp_out));
      check_field("last", 64'(want.last), 64'(got.last));
    end
  endfunction

  // Driver: hold the request while stalled, otherwise load the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_to_board(in_req);
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (requests_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if (sent_count == PAUSE_AT && rank_reports_due.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!in_tail() && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_req   <= requests_to_send.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each accepted result and drive the receiver's stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        compare_report(out_res);
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && sent_count >= LONG_AT) begin
        long_hold_done = 1'b1;
        recv_hold = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
        recv_hold = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic signed [SCORE_W-1:0] corner_scores[4];
    in_req_t rq;
    int k;

    corner_scores[0] = 32'sh7fffffff;
    corner_scores[1] = 32'sh80000000;
    corner_scores[2] = 32'sd0;
    corner_scores[3] = -32'sd1;

    requests_to_send.push_back(make_read());
    requests_to_send.push_back(make_insert(64'h0, 32'sd0, 32'h0));
    requests_to_send.push_back(make_insert({64{1'b1}}, 32'sh7fffffff, 32'hffffffff));
    requests_to_send.push_back(make_insert(64'h5555aaaa5555aaaa, 32'sh80000000, 32'h1));
    requests_to_send.push_back(make_insert(64'haaaa5555aaaa5555, -32'sd1, 32'h80000000));
    requests_to_send.push_back(make_insert(64'h0123456789abcdef, 32'sd0, 32'h7fffffff));
    requests_to_send.push_back(make_insert(64'hfedcba9876543210, 32'sh7fffffff, 32'h2));
    requests_to_send.push_back(make_insert(64'h8000000000000001, 32'sh80000000, 32'h3));
    requests_to_send.push_back(make_read());

    for (k = 0; k < RANDOM_REQS; k++) begin
      rq.cmd       = ($urandom_range(0, 99) < 65) ? CMD_INSERT : CMD_READ;
      rq.entry_tag = {$urandom, $urandom};
      rq.stamp     = $urandom;
      case ($urandom_range(0, 7))
        0, 1: rq.new_score = $urandom_range(0, 6) - 3;
        2:    rq.new_score = corner_scores[2'($urandom_range(0, 3))];
        default: rq.new_score = $urandom;
      endcase
      requests_to_send.push_back(rq);
    end
    total_reqs = requests_to_send.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (sent_count == total_reqs);
    while (rank_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && rank_reports_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bssl_pkg.sv
rtl/bssl_ctrl.sv
rtl/bssl_dp.sv
rtl/bounded_sorted_score_list.sv
tb/tb.sv
